### sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int REM_W  = 3;
    localparam int KIND_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNC   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    // Decode state carried between words
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CP_W-1:0]  acc;
    } t_dec_state;

    // Outcome of one step of the decoder
    typedef struct packed {
        t_dec_state        nxt;
        logic              res_vld;
        logic [CP_W-1:0]   code_point;
        logic [KIND_W-1:0] kind;
    } t_step_out;

endpackage

### sv/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// Single-byte decode step: from the current state and one byte, form the
// next state and at most one result.
// ----------------------------------------------------------------------------
module u8d_step (
    input  u8d_pkg::t_dec_state          i_state,
    input  logic [u8d_pkg::BYTE_W-1:0]   i_byte,
    output u8d_pkg::t_step_out           o_step
);

    logic [u8d_pkg::CP_W-1:0]  w_shifted;
    logic [u8d_pkg::REM_W-1:0] w_rem_dec;

    assign w_shifted = {i_state.acc[u8d_pkg::CP_W-7:0], i_byte[5:0]};
    assign w_rem_dec = i_state.rem - 3'd1;

    always_comb begin
        o_step.nxt        = i_state;
        o_step.res_vld    = 1'b0;
        o_step.code_point = '0;
        o_step.kind       = u8d_pkg::KIND_CHAR;

        if (i_state.rem != '0) begin
            if (i_byte == '0) begin
                // drop the partial sequence
                o_step.nxt.rem = '0;
                o_step.nxt.acc = '0;
                o_step.res_vld = 1'b1;
                o_step.kind    = u8d_pkg::KIND_TRUNC;
            end else if (w_rem_dec == '0) begin
                o_step.nxt.rem    = '0;
                o_step.nxt.acc    = '0;
                o_step.res_vld    = 1'b1;
                o_step.code_point = w_shifted;
            end else begin
                o_step.nxt.rem = w_rem_dec;
                o_step.nxt.acc = w_shifted;
            end
        end else if (i_byte == '0) begin
            o_step.res_vld = 1'b1;
            o_step.kind    = u8d_pkg::KIND_END;
        end else if (!i_byte[7]) begin
            o_step.res_vld    = 1'b1;
            o_step.code_point = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, i_byte};
        end else if (!i_byte[6] || i_byte[7:1] == 7'h7F) begin
            // stray continuation, 0xFE or 0xFF: consumed alone
            o_step.res_vld = 1'b1;
            o_step.kind    = u8d_pkg::KIND_INVALID;
        end else if (!i_byte[5]) begin
            o_step.nxt.rem = 3'd1;
            o_step.nxt.acc = {{(u8d_pkg::CP_W-5){1'b0}}, i_byte[4:0]};
        end else if (!i_byte[4]) begin
            o_step.nxt.rem = 3'd2;
            o_step.nxt.acc = {{(u8d_pkg::CP_W-4){1'b0}}, i_byte[3:0]};
        end else if (!i_byte[3]) begin
            o_step.nxt.rem = 3'd3;
            o_step.nxt.acc = {{(u8d_pkg::CP_W-3){1'b0}}, i_byte[2:0]};
        end else if (!i_byte[2]) begin
            o_step.nxt.rem = 3'd4;
            o_step.nxt.acc = {{(u8d_pkg::CP_W-2){1'b0}}, i_byte[1:0]};
        end else begin
            o_step.nxt.rem = 3'd5;
            o_step.nxt.acc = {{(u8d_pkg::CP_W-1){1'b0}}, i_byte[0]};
        end
    end

endmodule

### sv/utf8_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// UTF-8 decoder (original six-byte form), one text byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one raw text byte per word in s_axis_tdata.
//   The master channel gives one result word per completed character, end
//   of text, truncated sequence or invalid lead byte: the code point in
//   m_axis_tdata and the result kind in m_axis_tuser. Lead bytes and inner
//   continuation bytes produce no word.
//   The result word shows on the master side once the byte that completes it
//   has landed in the input register and the decode step has loaded the
//   result register from it; a master-side stall can delay that second load.
//   Throughput is one byte per clock unless the receiver stalls; the decode
//   step is a single shallow compare-and-shift between the two registers.
//   When the receiver stalls, the result register holds its word and the
//   input register keeps taking bytes that produce no result; a byte that
//   does produce one waits in the input register, and s_axis_tready drops
//   only while both registers are full and m_axis_tready is low.
//   Synchronous active-low reset clears both valid flags and the decode
//   state (no sequence in progress).
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    logic                       r_in_vld;
    logic [u8d_pkg::BYTE_W-1:0] r_in_byte;
    u8d_pkg::t_dec_state        r_state;
    logic                       r_out_vld;
    logic [u8d_pkg::CP_W-1:0]   r_out_cp;
    logic [u8d_pkg::KIND_W-1:0] r_out_kind;

    u8d_pkg::t_step_out         w_step;
    logic                       w_advance;

    u8d_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_step  (w_step)
    );

    // a byte with no result always moves on; one with a result needs room
    assign w_advance     = r_in_vld && (!w_step.res_vld || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_state.rem <= '0;
            r_state.acc <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_vld  <= 1'b1;
                r_in_byte <= s_axis_tdata;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end

            if (w_advance) begin
                r_state <= w_step.nxt;
            end

            if (w_advance && w_step.res_vld) begin
                r_out_vld  <= 1'b1;
                r_out_cp   <= w_step.code_point;
                r_out_kind <= w_step.kind;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_cp};
    assign m_axis_tuser  = r_out_kind;

endmodule

### sv/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // only characters carry a code point
    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != u8d_pkg::KIND_CHAR |-> m_axis_tdata == 32'd0)
        else $error("non-character result with nonzero code point");

    // pad bit above the 31-bit code point stays clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31])
        else $error("pad bit set in result word");

    // no result word at the first edge out of reset
    a_rst_clear: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // with no byte at the first edge out of reset, no early word shows
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) && !(s_axis_tvalid && s_axis_tready) |=>
            !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result word without an accepted byte");

endmodule

bind utf8_byte_stream_decoder_top u8d_checker u_u8d_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-byte UTF-8 byte stream decoder. Bytes go in
// on the slave stream; a local decoder predicts any result word due for each
// accepted byte, and every result word on the master stream is compared with
// the oldest prediction. Directed cases come first, then random text made
// mostly of well-formed sequences, under several source/sink idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [u8d_pkg::CP_W-1:0]   cp;
        logic [u8d_pkg::KIND_W-1:0] kind;
    } t_expected;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [30:0] code_point, [31] zero
    logic [1:0]  m_axis_tuser;            // [1:0] kind

    // Local copy of the decode state
    logic [u8d_pkg::REM_W-1:0] dec_rem = '0;
    logic [u8d_pkg::CP_W-1:0]  dec_acc = '0;

    t_expected pending_results[$];
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int n_bytes = 0;
    int n_results = 0;
    int n_errors = 0;
    int kind_count[4] = '{0, 0, 0, 0};

    utf8_byte_stream_decoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("utf8_byte_stream_decoder_top: mismatch");
        $finish;
    end

    // Advance the local decoder by one byte; return 1 when a word is due.
    function automatic bit decode_byte(input logic [7:0] b, output t_expected r);
        r.cp   = '0;
        r.kind = u8d_pkg::KIND_CHAR;
        if (dec_rem != 0) begin
            if (b == 8'h00) begin
                dec_rem = '0;
                dec_acc = '0;
                r.kind  = u8d_pkg::KIND_TRUNC;
                return 1'b1;
            end
            // any nonzero byte counts as a continuation, low six bits only
            dec_acc = {dec_acc[u8d_pkg::CP_W-7:0], b[5:0]};
            dec_rem = dec_rem - 3'd1;
            if (dec_rem == 0) begin
                r.cp    = dec_acc;
                dec_acc = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b == 8'h00) begin
            r.kind = u8d_pkg::KIND_END;
            return 1'b1;
        end
        if (!b[7]) begin
            r.cp = {{(u8d_pkg::CP_W-8){1'b0}}, b};
            return 1'b1;
        end
        if (b < 8'hC0 || b >= 8'hFE) begin
            r.kind = u8d_pkg::KIND_INVALID;
            return 1'b1;
        end
        casez (b)
            8'b110?????: begin dec_rem = 3'd1; dec_acc = {26'b0, b[4:0]}; end
            8'b1110????: begin dec_rem = 3'd2; dec_acc = {27'b0, b[3:0]}; end
            8'b11110???: begin dec_rem = 3'd3; dec_acc = {28'b0, b[2:0]}; end
            8'b111110??: begin dec_rem = 3'd4; dec_acc = {29'b0, b[1:0]}; end
            default:     begin dec_rem = 3'd5; dec_acc = {30'b0, b[0]};   end
        endcase
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_expected r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        n_bytes++;
        if (decode_byte(b, r))
            pending_results = {pending_results, r};
    endtask

    // Hold the source off until every predicted word has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_sequence(input int len);
        logic [7:0] lead;
        lead = 8'($urandom);
        case (len)
            1: lead = {1'b0, lead[6:0] == 7'd0 ? 7'd1 : lead[6:0]};
            2: lead = {3'b110, lead[4:0]};
            3: lead = {4'b1110, lead[3:0]};
            4: lead = {5'b11110, lead[2:0]};
            5: lead = {6'b111110, lead[1:0]};
            default: lead = {7'b1111110, lead[0]};
        endcase
        send_byte(lead);
        for (int i = 1; i < len; i++)
            send_byte({2'b10, 6'($urandom)});
    endtask

    // Checker and sink pacing share one process.
    always @(posedge i_clk) begin : result_check
        t_expected want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            kind_count[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                if (n_errors < 10)
                    $display("ERROR: unexpected word cp=%h kind=%0d",
                             m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== {1'b0, want.cp} || m_axis_tuser !== want.kind) begin
                    if (n_errors < 10)
                        $display({"ERROR: word %0d expected cp=%h kind=%0d,",
                                  " got tdata=%h kind=%0d"},
                                 n_results, want.cp, want.kind, m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic test_plain_and_control();
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hFE);
        send_byte(8'hFF);
    endtask

    task automatic test_longest_sequences();
        // six bytes fill all 31 code point bits
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
        send_byte(8'hF8);
        repeat (4) send_byte(8'h80);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'h00);
        // non-continuation byte is still taken as one
        send_byte(8'hC3);
        send_byte(8'h41);
    endtask

    task automatic test_random_text(input int n_items);
        int stop_at;
        int pick;
        int len;
        stop_at = n_bytes + n_items;
        while (n_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_sequence($urandom_range(1, 6));
            end else if (pick < 68) begin
                send_byte(8'h00);
            end else if (pick < 78) begin
                send_byte($urandom_range(3) == 0 ? 8'($urandom_range(254, 255))
                                                 : {2'b10, 6'($urandom)});
            end else if (pick < 88) begin
                len = $urandom_range(2, 6);
                send_byte(len == 2 ? 8'hDF : len == 3 ? 8'hEF : len == 4 ? 8'hF7 :
                          len == 5 ? 8'hFB : 8'hFD);
                repeat ($urandom_range(0, len - 2)) send_byte({2'b10, 6'($urandom)});
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom));
            end
            if (n_bytes >= stop_at - n_items / 2 && n_bytes < stop_at - n_items / 2 + 6)
                drain_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_and_control();
        test_longest_sequences();
        test_broken_sequences();
        drain_results();

        test_random_text(200);
        src_idle_pct = 47;
        test_random_text(200);
        src_idle_pct  = 0;
        snk_stall_pct = 47;
        test_random_text(200);
        src_idle_pct  = 34;
        snk_stall_pct = 34;
        test_random_text(200);

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d words: %0d chars, %0d ends, %0d truncated,",
                 n_bytes, n_results, kind_count[u8d_pkg::KIND_CHAR],
                 kind_count[u8d_pkg::KIND_END], kind_count[u8d_pkg::KIND_TRUNC]);
        $display("%0d invalid leads; %0d mismatches, %0d words never seen.",
                 kind_count[u8d_pkg::KIND_INVALID], n_errors, pending_results.size());
        if (n_errors == 0 && pending_results.size() == 0)
            $display("utf8_byte_stream_decoder_top: match");
        else
            $display("utf8_byte_stream_decoder_top: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/u8d_pkg.sv
sv/u8d_step.sv
sv/utf8_byte_stream_decoder_top.sv
sv/u8d_checker.sv
tb/sv/testbench.sv
